### src/zre_pkg.sv
// Shared types and constants for the zero-run encoder.
package zre_pkg;

  // Width of the run-length field, in bytes (little-endian on the output).
  localparam int COUNT_BYTES = 2;
  localparam int RUN_W       = 8 * COUNT_BYTES;
  localparam int CAP_W       = 24;
  localparam int LOST_W      = 32;
  // Step counter: holds the per-item byte count, up to COUNT_BYTES + 2.
  localparam int STEP_W      = $clog2(COUNT_BYTES + 3);

  localparam logic [RUN_W-1:0]  RUN_FULL     = '1;
  localparam logic [STEP_W-1:0] TOKEN_BYTES  = STEP_W'(COUNT_BYTES + 1);
  localparam logic [7:0]        ZERO_MARKER  = 8'h00;
  localparam logic [CAP_W-1:0]  CAP_RESET    = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              buffer_end;
    logic [CAP_W-1:0]  written_count;
    logic [LOST_W-1:0] dropped_count;
  } out_item_t;

  // Command from the classifier to the emitter: an optional run token
  // followed by an optional raw byte.
  typedef struct packed {
    logic             token;
    logic [RUN_W-1:0] run;
    logic             has_byte;
    logic [7:0]       raw;
    logic             last;
  } cmd_t;

endpackage

### src/zre_fifo.sv
// Small register-based FIFO used between the stages and at the output.
module zre_fifo
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 2)
  (input  logic             clk,
   input  logic             rst,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

### src/zre_front.sv
// Front stage: tracks the pending zero run and turns items into commands (zero bytes inside a run make none).
module zre_front
  import zre_pkg::*;
  (input  logic     clk,
   input  logic     rst,
   input  logic     accept,
   input  in_item_t item,
   output logic     cmd_push,
   output cmd_t     cmd);

  logic [RUN_W-1:0] zero_run;
  logic [RUN_W-1:0] zero_run_next;
  logic [RUN_W-1:0] run_inc;
  logic [RUN_W-1:0] run_after;

  always_comb begin
    run_inc       = zero_run + RUN_W'(1);
    cmd.raw       = item.data_byte;
    cmd.last      = item.last_byte;
    if (item.data_byte != 8'h00) begin
      cmd.token    = (zero_run != '0);
      cmd.run      = zero_run;
      cmd.has_byte = 1'b1;
      run_after    = '0;
    end else begin
      // counter hit all ones: flush the token right away
      cmd.token    = (run_inc == RUN_FULL);
      cmd.run      = run_inc;
      cmd.has_byte = 1'b0;
      run_after    = cmd.token ? '0 : run_inc;
    end
    if (item.last_byte && run_after != '0) begin
      cmd.token = 1'b1;
      cmd.run   = run_after;
    end
    zero_run_next = item.last_byte ? '0 : run_after;
    cmd_push      = accept && (cmd.token || cmd.has_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run <= '0;
    end else if (accept) begin
      zero_run <= zero_run_next;
    end
  end

endmodule

### src/zre_back.sv
// Back stage: emits command bytes one per cycle while the result queue has room, applies capacity, keeps totals.
module zre_back
  import zre_pkg::*;
  (input  logic             clk,
   input  logic             rst,
   input  logic [CAP_W-1:0] capacity,
   input  cmd_t             cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  logic             res_full,
   output logic             res_push,
   output out_item_t        res);

  logic [STEP_W-1:0]  idx;
  logic [STEP_W-1:0]  idx_next;
  logic [CAP_W-1:0]   kept;
  logic [CAP_W-1:0]   kept_next;
  logic [LOST_W-1:0]  lost;
  logic [LOST_W-1:0]  lost_next;

  logic               go;
  logic [STEP_W-1:0]  n_bytes;
  logic [STEP_W-1:0]  left;      // bytes of this item still to come, this one included
  logic [STEP_W-1:0]  tok_sel;
  logic [RUN_W-1:0]   run_shift;
  logic [7:0]         cur_byte;
  logic               room;
  logic               final_kept;
  logic [CAP_W-1:0]   kept_inc;
  logic [LOST_W:0]    lost_sum;
  logic [LOST_W-1:0]  lost_sat;

  always_comb begin
    go        = !cmd_empty && !res_full;
    n_bytes   = (cmd.token ? TOKEN_BYTES : '0) + STEP_W'(cmd.has_byte);
    left      = n_bytes - idx;
    tok_sel   = idx - STEP_W'(1);
    run_shift = cmd.run >> {tok_sel, 3'b000};
    if (cmd.token && idx == '0) begin
      cur_byte = ZERO_MARKER;
    end else if (cmd.token && idx < TOKEN_BYTES) begin
      cur_byte = run_shift[7:0];
    end else begin
      cur_byte = cmd.raw;
    end

    room     = (kept < capacity);
    kept_inc = kept + CAP_W'(1);
    // once this byte is kept, the rest of the item is dropped if capacity is now used up
    final_kept = (left == STEP_W'(1)) || (kept_inc == capacity);
    // drops charged now: later bytes when kept, all remaining bytes otherwise
    lost_sum = {1'b0, lost} + (LOST_W + 1)'(room ? left - STEP_W'(1) : left);
    lost_sat = lost_sum[LOST_W] ? '1 : lost_sum[LOST_W-1:0];

    res           = '0;
    res_push      = 1'b0;
    cmd_pop       = 1'b0;
    idx_next      = idx;
    kept_next     = kept;
    lost_next     = lost;

    if (go) begin
      if (room) begin
        res_push       = 1'b1;
        res.out_byte   = cur_byte;
        res.byte_valid = 1'b1;
        res.run_last   = final_kept;
        kept_next      = kept_inc;
        if (final_kept) begin
          cmd_pop   = 1'b1;
          idx_next  = '0;
          lost_next = lost_sat;
          if (cmd.last) begin
            res.buffer_end    = 1'b1;
            res.written_count = kept_inc;
            res.dropped_count = lost_sat;
          end
        end else begin
          idx_next = idx + STEP_W'(1);
        end
      end else begin
        // no byte of this item is kept; only the buffer end reports
        cmd_pop   = 1'b1;
        idx_next  = '0;
        lost_next = lost_sat;
        if (cmd.last) begin
          res_push          = 1'b1;
          res.run_last      = 1'b1;
          res.buffer_end    = 1'b1;
          res.written_count = kept;
          res.dropped_count = lost_sat;
        end
      end
      if (cmd_pop && cmd.last) begin
        kept_next = '0;
        lost_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      kept <= '0;
      lost <= '0;
    end else begin
      idx  <= idx_next;
      kept <= kept_next;
      lost <= lost_next;
    end
  end

endmodule

### src/zero_run_encoder_top.sv
// Top level of the zero-run encoder: front classifier, command queue, emitter, result queue.
//
// One source byte is taken per cycle while the command queue has room. A
// nonzero byte makes one emitter result, a run token makes COUNT_BYTES+1
// results (marker plus little-endian length), so an item that closes a run
// makes up to COUNT_BYTES+2 results; the emitter, which writes one result
// per cycle into the result queue while that queue has room, sets the
// sustained rate. Zero bytes inside a run take no emitter time. Bytes past
// the capacity register are dropped, and once the capacity is used up the
// rest of an item is dropped as a whole rather than byte by byte. The last
// result of each buffer carries the kept and dropped totals. Write the
// capacity only while the block is idle.
module zero_run_encoder_top
  import zre_pkg::*;
  #(parameter int CMD_DEPTH = 2,
    parameter int OUT_DEPTH = 2)
  (input  logic             clk,
   input  logic             rst,
   input  logic             push,
   input  in_item_t         item,
   output logic             full,
   input  logic             pop,
   output out_item_t        result,
   output logic             empty,
   input  logic             cfg_valid,
   output logic             cfg_ready,
   input  logic [CAP_W-1:0] cfg_data);

  logic [CAP_W-1:0] capacity;
  logic             accept;
  logic             cmd_push;
  cmd_t             cmd_in;
  cmd_t             cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  out_item_t        res;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  zre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  zre_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  zre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  zre_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
